FILE: sv/dpod_pkg.sv
package dpod_pkg;

    localparam int DayW    = 5;
    localparam int MonW    = 4;
    localparam int YearW   = 14;
    localparam int QuoW    = 8;
    localparam int RemW    = 7;
    localparam int ProdW   = 24;
    localparam int SerialW = 24;
    localparam int CountW  = 22;
    localparam int DbmW    = 9;
    localparam int MpartW  = 10;
    localparam int NumDates = 4;

    localparam logic [11:0]      Recip25     = 12'd2622;
    localparam logic [RemW-1:0]  Century     = 7'd100;
    localparam logic [SerialW-1:0] DaysInYear = 24'd365;
    localparam logic [MonW-1:0]  MonFirst    = 4'd1;
    localparam logic [MonW-1:0]  MonLast     = 4'd12;
    localparam logic [MonW-1:0]  MonFeb      = 4'd2;
    localparam logic [SerialW-1:0] CountMax  = 24'd4194303;

    typedef logic [DayW-1:0]    t_day;
    typedef logic [MonW-1:0]    t_mon;
    typedef logic [YearW-1:0]   t_year;
    typedef logic [SerialW-1:0] t_serial;
    typedef logic [CountW-1:0]  t_count;
    typedef logic [DbmW-1:0]    t_dbm;

    function automatic t_dbm days_before_month(input t_mon mon);
        t_dbm d;
        case (mon)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

FILE: sv/date_period_overlap_days.sv
// Counts the calendar days, both end days included, that two Gregorian date periods have in
// common. Each date is turned into a day serial number, and the overlap is the smaller end
// minus the larger start plus one; the count is 0 when the periods are disjoint or when either
// starts after it ends, and it saturates at the top of the 22-bit field. The block is a
// six-stage pipeline: one word is taken in every cycle while o_stall is low, and its result
// passes through the register stages r1 to r6 in order to the output. A stalled output holds
// only the stages behind it that are full, so empty stages still take new words.
module date_period_overlap_days (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  dpod_pkg::t_day    i_first_start_day,
    input  dpod_pkg::t_mon    i_first_start_month,
    input  dpod_pkg::t_year   i_first_start_year,
    input  dpod_pkg::t_day    i_first_end_day,
    input  dpod_pkg::t_mon    i_first_end_month,
    input  dpod_pkg::t_year   i_first_end_year,
    input  dpod_pkg::t_day    i_second_start_day,
    input  dpod_pkg::t_mon    i_second_start_month,
    input  dpod_pkg::t_year   i_second_start_year,
    input  dpod_pkg::t_day    i_second_end_day,
    input  dpod_pkg::t_mon    i_second_end_month,
    input  dpod_pkg::t_year   i_second_end_year,
    output logic              o_valid,
    input  logic              i_stall,
    output dpod_pkg::t_count  o_overlap_days,
    output logic              o_periods_overlap
);
    import dpod_pkg::*;

    logic [6:1] r_vld;
    logic [6:1] en_s;

    t_day    w_day  [NumDates];
    t_mon    w_mon  [NumDates];
    t_year   w_year [NumDates];

    t_day              r1_day  [NumDates];
    t_mon              r1_mon  [NumDates];
    t_year             r1_year [NumDates];
    logic [ProdW-1:0]  r1_prod [NumDates];

    t_day              r2_day  [NumDates];
    t_mon              r2_mon  [NumDates];
    t_year             r2_year [NumDates];
    logic [QuoW-1:0]   r2_quo  [NumDates];
    logic [RemW-1:0]   r2_rem  [NumDates];

    t_serial           r3_ypart [NumDates];
    logic [MpartW-1:0] r3_mpart [NumDates];

    t_serial           r4_serial [NumDates];

    logic              r5_ok;
    t_serial           r5_lo;
    t_serial           r5_hi;

    t_count            r6_count;
    logic              r6_flag;

    assign w_day[0]  = i_first_start_day;
    assign w_mon[0]  = i_first_start_month;
    assign w_year[0] = i_first_start_year;
    assign w_day[1]  = i_first_end_day;
    assign w_mon[1]  = i_first_end_month;
    assign w_year[1] = i_first_end_year;
    assign w_day[2]  = i_second_start_day;
    assign w_mon[2]  = i_second_start_month;
    assign w_year[2] = i_second_start_year;
    assign w_day[3]  = i_second_end_day;
    assign w_mon[3]  = i_second_end_month;
    assign w_year[3] = i_second_end_year;

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb begin
        en_s[6] = !r_vld[6] || !i_stall;
        for (int k = 5; k >= 1; k--) begin
            en_s[k] = !r_vld[k] || en_s[k+1];
        end
    end

    assign o_stall = !en_s[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en_s[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= 6; k++) begin
                if (en_s[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    for (genvar g = 0; g < NumDates; g++) begin : g_date
        t_mon              n_mon;
        logic [QuoW-1:0]   n_quo;
        logic [RemW-1:0]   n_rem;
        logic [RemW-1:0]   n_rem_prod;
        logic              n_rem_nz;
        logic              n_quo_nz;
        logic              n_leap;
        logic [YearW:0]    n_ceil4;
        logic [QuoW:0]     n_ceil100;
        logic [QuoW-2:0]   n_ceil400;
        t_serial           n_ypart;
        logic [MpartW-1:0] n_mpart;

        always_comb begin
            n_mon = w_mon[g];
            if (w_mon[g] < MonFirst) begin
                n_mon = MonFirst;
            end else if (w_mon[g] inside {[4'd13:4'd15]}) begin
                n_mon = MonLast;
            end
        end

        always_comb begin
            n_quo      = r1_prod[g][ProdW-1:ProdW-QuoW];
            n_rem_prod = RemW'(r1_year[g] - YearW'(n_quo) * YearW'(Century));
            n_rem      = n_rem_prod;
        end

        always_comb begin
            n_rem_nz  = (r2_rem[g] != '0);
            n_quo_nz  = (r2_quo[g][1:0] != 2'd0);
            n_leap    = n_rem_nz ? (r2_year[g][1:0] == 2'd0) : !n_quo_nz;
            n_ceil4   = (YearW+1)'((r2_year[g] + (YearW+1)'(3)) >> 2);
            n_ceil100 = (QuoW+1)'(r2_quo[g]) + (QuoW+1)'(n_rem_nz);
            n_ceil400 = (QuoW-1)'((r2_quo[g] >> 2) + QuoW'(n_rem_nz || n_quo_nz));
            n_ypart   = SerialW'(r2_year[g]) * DaysInYear + SerialW'(n_ceil4)
                        - SerialW'(n_ceil100) + SerialW'(n_ceil400);
            n_mpart   = MpartW'(days_before_month(r2_mon[g]))
                        + MpartW'(n_leap && (r2_mon[g] > MonFeb))
                        + MpartW'(r2_day[g]);
        end

        always_ff @(posedge i_clk) begin
            if (en_s[1]) begin
                r1_day[g]  <= w_day[g];
                r1_mon[g]  <= n_mon;
                r1_year[g] <= w_year[g];
                r1_prod[g] <= ProdW'(w_year[g][YearW-1:2]) * ProdW'(Recip25);
            end
            if (en_s[2]) begin
                r2_day[g]  <= r1_day[g];
                r2_mon[g]  <= r1_mon[g];
                r2_year[g] <= r1_year[g];
                r2_quo[g]  <= n_quo;
                r2_rem[g]  <= n_rem;
            end
            if (en_s[3]) begin
                r3_ypart[g] <= n_ypart;
                r3_mpart[g] <= n_mpart;
            end
            if (en_s[4]) begin
                r4_serial[g] <= r3_ypart[g] + SerialW'(r3_mpart[g]);
            end
        end
    end

    t_serial n_diff;

    always_comb begin
        n_diff = r5_hi - r5_lo + SerialW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (en_s[5]) begin
            r5_ok <= (r4_serial[0] <= r4_serial[1]) && (r4_serial[2] <= r4_serial[3]);
            r5_lo <= (r4_serial[0] > r4_serial[2]) ? r4_serial[0] : r4_serial[2];
            r5_hi <= (r4_serial[1] < r4_serial[3]) ? r4_serial[1] : r4_serial[3];
        end
        if (en_s[6]) begin
            if (!r5_ok || (r5_lo > r5_hi)) begin
                r6_count <= '0;
                r6_flag  <= 1'b0;
            end else begin
                r6_count <= (n_diff > CountMax) ? CountW'(CountMax) : CountW'(n_diff);
                r6_flag  <= 1'b1;
            end
        end
    end

    assign o_valid           = r_vld[6];
    assign o_overlap_days    = r6_count;
    assign o_periods_overlap = r6_flag;

`ifndef SYNTHESIS
    a_flag_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[6] |-> (r6_flag == (r6_count != '0)))
        else $error("overlap flag disagrees with the day count");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_vld == '1) && i_stall)
        else $error("input stalled while a stage is free");

    a_bubble_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[1] |-> !o_stall)
        else $error("empty first stage refused a word");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_vld[1])
        else $error("accepted word did not enter the first stage");
`endif

endmodule
